// ----- design/lxr_pkg.sv -----
// lexer package: character classes, token kinds, operator tables, beat types
package lxr_pkg;

   localparam int POS_OUT_BITS = 16;
   localparam int LEN_BITS     = 16;
   localparam int KIND_BITS    = 6;
   localparam int OP_BITS      = 4;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

   localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_STAR       = 8'h2A;
   localparam logic [7:0] CHAR_SLASH      = 8'h2F;
   localparam logic [7:0] CHAR_PERCENT    = 8'h25;
   localparam logic [7:0] CHAR_EQUAL      = 8'h3D;
   localparam logic [7:0] CHAR_LESS       = 8'h3C;
   localparam logic [7:0] CHAR_GREATER    = 8'h3E;
   localparam logic [7:0] CHAR_NONE       = 8'h00;

   localparam logic [KIND_BITS-1:0] KIND_END          = 6'd0;
   localparam logic [KIND_BITS-1:0] KIND_ASSIGN       = 6'd1;
   localparam logic [KIND_BITS-1:0] KIND_PLUS         = 6'd2;
   localparam logic [KIND_BITS-1:0] KIND_MINUS        = 6'd3;
   localparam logic [KIND_BITS-1:0] KIND_ASTERISK     = 6'd4;
   localparam logic [KIND_BITS-1:0] KIND_SLASH        = 6'd5;
   localparam logic [KIND_BITS-1:0] KIND_MODULO       = 6'd6;
   localparam logic [KIND_BITS-1:0] KIND_EQUAL        = 6'd14;
   localparam logic [KIND_BITS-1:0] KIND_LESSTHAN     = 6'd16;
   localparam logic [KIND_BITS-1:0] KIND_LESSEQUAL    = 6'd17;
   localparam logic [KIND_BITS-1:0] KIND_GREATERTHAN  = 6'd18;
   localparam logic [KIND_BITS-1:0] KIND_GREATEREQUAL = 6'd19;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER       = 6'd20;
   localparam logic [KIND_BITS-1:0] KIND_IDENTIFIER   = 6'd21;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN       = 6'd22;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN       = 6'd23;
   localparam logic [KIND_BITS-1:0] KIND_LBRACKET     = 6'd24;
   localparam logic [KIND_BITS-1:0] KIND_RBRACKET     = 6'd25;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE       = 6'd26;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE       = 6'd27;
   localparam logic [KIND_BITS-1:0] KIND_COMMA        = 6'd31;
   localparam logic [KIND_BITS-1:0] KIND_COLON        = 6'd32;
   localparam logic [KIND_BITS-1:0] KIND_DOUBLESLASH  = 6'd35;
   localparam logic [KIND_BITS-1:0] KIND_INCREMENT    = 6'd37;
   localparam logic [KIND_BITS-1:0] KIND_DECREMENT    = 6'd38;
   localparam logic [KIND_BITS-1:0] KIND_ADD_ASSIGN   = 6'd39;
   localparam logic [KIND_BITS-1:0] KIND_SUB_ASSIGN   = 6'd40;
   localparam logic [KIND_BITS-1:0] KIND_MUL_ASSIGN   = 6'd41;
   localparam logic [KIND_BITS-1:0] KIND_DIV_ASSIGN   = 6'd42;
   localparam logic [KIND_BITS-1:0] KIND_MOD_ASSIGN   = 6'd43;
   localparam logic [KIND_BITS-1:0] KIND_TERNARY      = 6'd44;

   localparam logic [OP_BITS-1:0] OP_NONE    = 4'd0;
   localparam logic [OP_BITS-1:0] OP_PLUS    = 4'd1;
   localparam logic [OP_BITS-1:0] OP_MINUS   = 4'd2;
   localparam logic [OP_BITS-1:0] OP_STAR    = 4'd3;
   localparam logic [OP_BITS-1:0] OP_SLASH   = 4'd4;
   localparam logic [OP_BITS-1:0] OP_PERCENT = 4'd5;
   localparam logic [OP_BITS-1:0] OP_EQUAL   = 4'd6;
   localparam logic [OP_BITS-1:0] OP_LESS    = 4'd7;
   localparam logic [OP_BITS-1:0] OP_GREATER = 4'd8;

   localparam logic [1:0] WORD_NONE   = 2'd0;
   localparam logic [1:0] WORD_NUMBER = 2'd1;
   localparam logic [1:0] WORD_IDENT  = 2'd2;

   typedef enum logic [2:0] {
      CLS_SPACE,
      CLS_DIGIT,
      CLS_ALPHA,
      CLS_OP,
      CLS_SINGLE,
      CLS_BAD
   } class_type;

   typedef struct packed {
      logic [7:0]              text_byte;
      logic                    end_of_text;
      logic [POS_OUT_BITS-1:0] pos;
      class_type               char_class;
      logic [OP_BITS-1:0]      op_code;
      logic [KIND_BITS-1:0]    single_kind;
   } item_type;

   typedef struct packed {
      logic                    is_error;
      logic [KIND_BITS-1:0]    token_kind;
      logic [POS_OUT_BITS-1:0] token_start;
      logic [LEN_BITS-1:0]     token_length;
      logic [7:0]              bad_char;
      logic                    last_of_run;
   } result_type;

   function automatic logic [OP_BITS-1:0] op_of_char(logic [7:0] c);
      logic [OP_BITS-1:0] k;
      case (c)
         CHAR_PLUS:    k = OP_PLUS;
         CHAR_MINUS:   k = OP_MINUS;
         CHAR_STAR:    k = OP_STAR;
         CHAR_SLASH:   k = OP_SLASH;
         CHAR_PERCENT: k = OP_PERCENT;
         CHAR_EQUAL:   k = OP_EQUAL;
         CHAR_LESS:    k = OP_LESS;
         CHAR_GREATER: k = OP_GREATER;
         default:      k = OP_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [KIND_BITS-1:0] single_of_char(logic [7:0] c);
      logic [KIND_BITS-1:0] k;
      case (c)
         8'h3F:   k = KIND_TERNARY;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h5B:   k = KIND_LBRACKET;
         8'h5D:   k = KIND_RBRACKET;
         8'h7B:   k = KIND_LBRACE;
         8'h7D:   k = KIND_RBRACE;
         8'h2C:   k = KIND_COMMA;
         8'h3A:   k = KIND_COLON;
         default: k = KIND_END;
      endcase
      return k;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic [KIND_BITS-1:0] op_single(logic [OP_BITS-1:0] k);
      logic [KIND_BITS-1:0] r;
      case (k)
         OP_PLUS:    r = KIND_PLUS;
         OP_MINUS:   r = KIND_MINUS;
         OP_STAR:    r = KIND_ASTERISK;
         OP_SLASH:   r = KIND_SLASH;
         OP_PERCENT: r = KIND_MODULO;
         OP_EQUAL:   r = KIND_ASSIGN;
         OP_LESS:    r = KIND_LESSTHAN;
         OP_GREATER: r = KIND_GREATERTHAN;
         default:    r = KIND_END;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] op_sec_a(logic [OP_BITS-1:0] k);
      logic [7:0] r;
      case (k)
         OP_PLUS:  r = CHAR_PLUS;
         OP_MINUS: r = CHAR_MINUS;
         OP_STAR, OP_SLASH, OP_PERCENT, OP_EQUAL, OP_LESS, OP_GREATER: r = CHAR_EQUAL;
         default:  r = CHAR_NONE;
      endcase
      return r;
   endfunction

   function automatic logic [KIND_BITS-1:0] op_kind_a(logic [OP_BITS-1:0] k);
      logic [KIND_BITS-1:0] r;
      case (k)
         OP_PLUS:    r = KIND_INCREMENT;
         OP_MINUS:   r = KIND_DECREMENT;
         OP_STAR:    r = KIND_MUL_ASSIGN;
         OP_SLASH:   r = KIND_DIV_ASSIGN;
         OP_PERCENT: r = KIND_MOD_ASSIGN;
         OP_EQUAL:   r = KIND_EQUAL;
         OP_LESS:    r = KIND_LESSEQUAL;
         OP_GREATER: r = KIND_GREATEREQUAL;
         default:    r = KIND_END;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] op_sec_b(logic [OP_BITS-1:0] k);
      logic [7:0] r;
      case (k)
         OP_PLUS:  r = CHAR_EQUAL;
         OP_MINUS: r = CHAR_EQUAL;
         OP_SLASH: r = CHAR_SLASH;
         default:  r = CHAR_NONE;
      endcase
      return r;
   endfunction

   function automatic logic [KIND_BITS-1:0] op_kind_b(logic [OP_BITS-1:0] k);
      logic [KIND_BITS-1:0] r;
      case (k)
         OP_PLUS:  r = KIND_ADD_ASSIGN;
         OP_MINUS: r = KIND_SUB_ASSIGN;
         OP_SLASH: r = KIND_DOUBLESLASH;
         default:  r = KIND_END;
      endcase
      return r;
   endfunction

endpackage

// ----- design/lxr_ifs.sv -----
// valid/ready channel interfaces for text bytes and token results
interface lxr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface lxr_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_error;
   logic [5:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic [7:0]  bad_char;
   logic        last_of_run;

   modport source (output valid, output is_error, output token_kind, output token_start,
                   output token_length, output bad_char, output last_of_run, input ready);
   modport sink (input valid, input is_error, input token_kind, input token_start,
                 input token_length, input bad_char, input last_of_run, output ready);
endinterface

// ----- design/lxr_front.sv -----
// front end: accepts text beats, tracks position and classifies each byte
module lxr_front #(
   parameter int POSITION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   output logic              in_ready,
   input  logic              q_ready,
   output logic              q_valid,
   output lxr_pkg::item_type q_item
);

   logic [POSITION_BITS-1:0]         pos_ff;
   logic [POSITION_BITS-1:0]         pos_in;
   logic [lxr_pkg::POS_OUT_BITS-1:0] pos_low;
   logic                             accept;
   logic [lxr_pkg::OP_BITS-1:0]      op_k;
   logic [lxr_pkg::KIND_BITS-1:0]    single_k;

   generate
      if (POSITION_BITS >= lxr_pkg::POS_OUT_BITS) begin : g_pos_wide
         assign pos_low = pos_ff[lxr_pkg::POS_OUT_BITS-1:0];
      end else begin : g_pos_narrow
         assign pos_low = {{(lxr_pkg::POS_OUT_BITS-POSITION_BITS){1'b0}}, pos_ff};
      end
   endgenerate

   assign in_ready = q_ready;
   assign q_valid  = in_valid;
   assign accept   = in_valid && q_ready;
   assign op_k     = lxr_pkg::op_of_char(in_byte);
   assign single_k = lxr_pkg::single_of_char(in_byte);

   always_comb begin
      q_item.text_byte   = in_byte;
      q_item.end_of_text = in_last;
      q_item.pos         = pos_low;
      q_item.op_code     = op_k;
      q_item.single_kind = single_k;
      if (lxr_pkg::is_space(in_byte)) begin
         q_item.char_class = lxr_pkg::CLS_SPACE;
      end else if (lxr_pkg::is_digit(in_byte)) begin
         q_item.char_class = lxr_pkg::CLS_DIGIT;
      end else if (lxr_pkg::is_alpha(in_byte) || in_byte == lxr_pkg::CHAR_UNDERSCORE) begin
         q_item.char_class = lxr_pkg::CLS_ALPHA;
      end else if (op_k != lxr_pkg::OP_NONE) begin
         q_item.char_class = lxr_pkg::CLS_OP;
      end else if (single_k != lxr_pkg::KIND_END) begin
         q_item.char_class = lxr_pkg::CLS_SINGLE;
      end else begin
         q_item.char_class = lxr_pkg::CLS_BAD;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = in_last ? '0 : pos_ff + POSITION_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ----- design/lxr_queue.sv -----
// short queue of classified bytes between front and back
module lxr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  lxr_pkg::item_type push_item,
   output logic              push_ready,
   output logic              head_valid,
   output lxr_pkg::item_type head_item,
   input  logic              pop
);

   lxr_pkg::item_type                mem_ff [lxr_pkg::QUEUE_DEPTH];
   logic [lxr_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [lxr_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [lxr_pkg::QPTR_BITS:0]      count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign push_ready = count_ff != (lxr_pkg::QPTR_BITS+1)'(lxr_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + lxr_pkg::QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + lxr_pkg::QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (lxr_pkg::QPTR_BITS+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (lxr_pkg::QPTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/lxr_back.sv -----
// back end: lexer state, token generation and output register
module lxr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  lxr_pkg::item_type   head_item,
   output logic                pop,
   output logic                out_valid,
   output lxr_pkg::result_type out_beat,
   input  logic                out_ready
);

   localparam int NCAND = 5;

   logic [lxr_pkg::OP_BITS-1:0]      pend_op_ff, pend_op_in;
   logic [1:0]                       word_kind_ff, word_kind_in;
   logic [lxr_pkg::POS_OUT_BITS-1:0] word_start_ff, word_start_in;
   logic [lxr_pkg::LEN_BITS-1:0]     word_len_ff, word_len_in;
   logic                             phase_ff, phase_in;
   logic                             out_valid_ff, out_valid_in;
   lxr_pkg::result_type              out_ff, out_in;

   lxr_pkg::result_type              cand [NCAND];
   logic [NCAND-1:0]                 cand_v;
   lxr_pkg::result_type              res0, res1, sel;
   logic [1:0]                       n_res;
   logic [2:0]                       cnt;
   logic                             done;
   logic                             word_live;
   logic                             cont;
   logic [7:0]                       c;
   logic                             load;
   logic                             final_beat;

   function automatic lxr_pkg::result_type make_token(
      logic [lxr_pkg::KIND_BITS-1:0]    kind,
      logic [lxr_pkg::POS_OUT_BITS-1:0] start,
      logic [lxr_pkg::LEN_BITS-1:0]     len
   );
      lxr_pkg::result_type r;
      r.is_error     = 1'b0;
      r.token_kind   = kind;
      r.token_start  = start;
      r.token_length = len;
      r.bad_char     = 8'h00;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   always_comb begin
      c             = head_item.text_byte;
      pend_op_in    = pend_op_ff;
      word_kind_in  = word_kind_ff;
      word_start_in = word_start_ff;
      word_len_in   = word_len_ff;
      done          = 1'b0;
      cont          = 1'b0;
      cand_v        = '0;
      for (int i = 0; i < NCAND; i++) begin
         cand[i] = '0;
      end

      // pending operator: two-character match or flush as single
      if (pend_op_in != lxr_pkg::OP_NONE && pend_op_in <= lxr_pkg::OP_GREATER) begin
         cand_v[0] = 1'b1;
         if (c == lxr_pkg::op_sec_a(pend_op_in)) begin
            cand[0] = make_token(lxr_pkg::op_kind_a(pend_op_in), word_start_in,
                                 lxr_pkg::LEN_BITS'(2));
            done    = 1'b1;
         end else if (lxr_pkg::op_sec_b(pend_op_in) != lxr_pkg::CHAR_NONE &&
                      c == lxr_pkg::op_sec_b(pend_op_in)) begin
            cand[0] = make_token(lxr_pkg::op_kind_b(pend_op_in), word_start_in,
                                 lxr_pkg::LEN_BITS'(2));
            done    = 1'b1;
         end else begin
            cand[0] = make_token(lxr_pkg::op_single(pend_op_in), word_start_in,
                                 lxr_pkg::LEN_BITS'(1));
         end
      end
      pend_op_in = lxr_pkg::OP_NONE;

      // word in progress: extend or flush
      word_live = word_kind_in == lxr_pkg::WORD_NUMBER || word_kind_in == lxr_pkg::WORD_IDENT;
      if (!done && word_live) begin
         if (word_kind_in == lxr_pkg::WORD_NUMBER) begin
            cont = head_item.char_class == lxr_pkg::CLS_DIGIT;
         end else begin
            cont = head_item.char_class == lxr_pkg::CLS_DIGIT ||
                   head_item.char_class == lxr_pkg::CLS_ALPHA;
         end
         if (cont) begin
            if (word_len_in != lxr_pkg::LEN_MAX) begin
               word_len_in = word_len_in + lxr_pkg::LEN_BITS'(1);
            end
            done = 1'b1;
         end else begin
            cand_v[1]    = 1'b1;
            cand[1]      = make_token(word_kind_in == lxr_pkg::WORD_NUMBER ?
                                      lxr_pkg::KIND_NUMBER : lxr_pkg::KIND_IDENTIFIER,
                                      word_start_in, word_len_in);
            word_kind_in = lxr_pkg::WORD_NONE;
            word_len_in  = '0;
         end
      end else if (!word_live) begin
         word_kind_in = lxr_pkg::WORD_NONE;
      end

      // start of something new
      if (!done) begin
         case (head_item.char_class)
            lxr_pkg::CLS_SPACE: begin
            end
            lxr_pkg::CLS_DIGIT: begin
               word_kind_in  = lxr_pkg::WORD_NUMBER;
               word_start_in = head_item.pos;
               word_len_in   = lxr_pkg::LEN_BITS'(1);
            end
            lxr_pkg::CLS_ALPHA: begin
               word_kind_in  = lxr_pkg::WORD_IDENT;
               word_start_in = head_item.pos;
               word_len_in   = lxr_pkg::LEN_BITS'(1);
            end
            lxr_pkg::CLS_OP: begin
               pend_op_in    = head_item.op_code;
               word_start_in = head_item.pos;
            end
            lxr_pkg::CLS_SINGLE: begin
               cand_v[2] = 1'b1;
               cand[2]   = make_token(head_item.single_kind, head_item.pos,
                                      lxr_pkg::LEN_BITS'(1));
            end
            default: begin
               cand_v[2]         = 1'b1;
               cand[2]           = make_token(lxr_pkg::KIND_END, head_item.pos,
                                              lxr_pkg::LEN_BITS'(1));
               cand[2].is_error  = 1'b1;
               cand[2].bad_char  = c;
            end
         endcase
      end

      // end of text flush
      if (head_item.end_of_text) begin
         if (pend_op_in != lxr_pkg::OP_NONE) begin
            cand_v[3] = 1'b1;
            cand[3]   = make_token(lxr_pkg::op_single(pend_op_in), word_start_in,
                                   lxr_pkg::LEN_BITS'(1));
         end
         if (word_kind_in != lxr_pkg::WORD_NONE) begin
            cand_v[4] = 1'b1;
            cand[4]   = make_token(word_kind_in == lxr_pkg::WORD_NUMBER ?
                                   lxr_pkg::KIND_NUMBER : lxr_pkg::KIND_IDENTIFIER,
                                   word_start_in, word_len_in);
         end
         pend_op_in   = lxr_pkg::OP_NONE;
         word_kind_in = lxr_pkg::WORD_NONE;
         word_len_in  = '0;
      end

      // first two results in order
      res0 = '0;
      res1 = '0;
      cnt  = '0;
      for (int i = 0; i < NCAND; i++) begin
         if (cand_v[i]) begin
            if (cnt == 3'd0) begin
               res0 = cand[i];
            end else if (cnt == 3'd1) begin
               res1 = cand[i];
            end
            cnt = cnt + 3'd1;
         end
      end
      n_res = cnt[1:0];
   end

   assign final_beat = phase_ff || (n_res == 2'd1);
   assign load       = head_valid && (n_res != 2'd0) && (!out_valid_ff || out_ready);
   assign pop        = head_valid && ((n_res == 2'd0) || (load && final_beat));

   always_comb begin
      sel             = phase_ff ? res1 : res0;
      sel.last_of_run = final_beat;
      out_in          = load ? sel : out_ff;
      out_valid_in    = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
      phase_in = phase_ff;
      if (pop) begin
         phase_in = 1'b0;
      end else if (load) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_op_ff    <= lxr_pkg::OP_NONE;
         word_kind_ff  <= lxr_pkg::WORD_NONE;
         word_start_ff <= '0;
         word_len_ff   <= '0;
         phase_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            pend_op_ff    <= pend_op_in;
            word_kind_ff  <= word_kind_in;
            word_start_ff <= word_start_in;
            word_len_ff   <= word_len_in;
         end
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_beat  = out_ff;

`ifndef SYNTHESIS
   a_phase_two_results: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (head_valid && n_res == 2'd2))
      else $error("second beat pending without a two-result byte");

   a_pop_after_second: assert property (@(posedge clock) disable iff (reset)
      (pop && n_res == 2'd2) |-> phase_ff)
      else $error("byte retired before its second result");

   a_op_word_exclusive: assert property (@(posedge clock) disable iff (reset)
      (pend_op_ff != lxr_pkg::OP_NONE) |-> (word_kind_ff == lxr_pkg::WORD_NONE))
      else $error("operator and word pending together");
`endif

endmodule

// ----- design/c_style_lexer.sv -----
// lexer top level: one text byte in per beat, tokens out with start and length
// accepted bytes are written into the queue; result beats are registered in the back end
// throughput: one byte per cycle if the queue has room; two-result bytes hold the back end
// a four-entry queue between front and back absorbs those holds and output stalls
// reset is synchronous: position, lexer state, queue and output valid are cleared
module c_style_lexer #(
   parameter int POSITION_BITS = 16
) (
   input logic      clock,
   input logic      reset,
   lxr_req_if.sink  req_if,
   lxr_rsp_if.source rsp_if
);

   logic                q_push_valid;
   logic                q_push_ready;
   lxr_pkg::item_type   q_push_item;
   logic                q_head_valid;
   lxr_pkg::item_type   q_head_item;
   logic                q_pop;
   lxr_pkg::result_type rsp_beat;

   lxr_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_byte  (req_if.text_byte),
      .in_last  (req_if.end_of_text),
      .in_ready (req_if.ready),
      .q_ready  (q_push_ready),
      .q_valid  (q_push_valid),
      .q_item   (q_push_item)
   );

   lxr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_item  (q_push_item),
      .push_ready (q_push_ready),
      .head_valid (q_head_valid),
      .head_item  (q_head_item),
      .pop        (q_pop)
   );

   lxr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_item  (q_head_item),
      .pop        (q_pop),
      .out_valid  (rsp_if.valid),
      .out_beat   (rsp_beat),
      .out_ready  (rsp_if.ready)
   );

   assign rsp_if.is_error     = rsp_beat.is_error;
   assign rsp_if.token_kind   = rsp_beat.token_kind;
   assign rsp_if.token_start  = rsp_beat.token_start;
   assign rsp_if.token_length = rsp_beat.token_length;
   assign rsp_if.bad_char     = rsp_beat.bad_char;
   assign rsp_if.last_of_run  = rsp_beat.last_of_run;

endmodule

// ----- verif/c_style_lexer_tb.sv -----
`timescale 1ns / 100ps
// c_style_lexer testbench: directed and random texts, every token beat checked against a predictor
module c_style_lexer_tb;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 10;
   localparam int LONG_WORD     = 300;
   localparam int RANDOM_ITEMS  = 620;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lxr_req_if req_if();
   lxr_rsp_if rsp_if();

   c_style_lexer #(
      .POSITION_BITS(16)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always #4 clock = ~clock;

   logic [lxr_pkg::OP_BITS-1:0]      held_op     = lxr_pkg::OP_NONE;
   logic [1:0]                       word_kind   = lxr_pkg::WORD_NONE;
   logic [lxr_pkg::POS_OUT_BITS-1:0] word_start  = '0;
   logic [lxr_pkg::LEN_BITS-1:0]     word_length = '0;
   logic [lxr_pkg::POS_OUT_BITS-1:0] next_pos    = '0;
   lxr_pkg::result_type              lexed_tokens [$];

   int mismatch_count  = 0;
   int cycle_count     = 0;
   int hold_cycles     = 0;
   bit sender_steady   = 1'b0;
   bit receiver_steady = 1'b0;

   function automatic bit digit_char(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic bit word_char(input logic [7:0] c);
      return digit_char(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
             || (c == lxr_pkg::CHAR_UNDERSCORE);
   endfunction

   function automatic lxr_pkg::result_type make_token(
      input logic [lxr_pkg::KIND_BITS-1:0] kind,
      input logic [lxr_pkg::POS_OUT_BITS-1:0] start,
      input logic [lxr_pkg::LEN_BITS-1:0] len);
      lxr_pkg::result_type t;
      t = '0;
      t.token_kind = kind;
      t.token_start = start;
      t.token_length = len;
      return t;
   endfunction

   task automatic add_beat(ref lxr_pkg::result_type beats [$],
                           input lxr_pkg::result_type t);
      beats.insert(beats.size(), t);
   endtask

   task automatic add_char(ref logic [7:0] text [$], input logic [7:0] c);
      text.insert(text.size(), c);
   endtask

   task automatic close_op(ref lxr_pkg::result_type beats [$]);
      logic [lxr_pkg::KIND_BITS-1:0] k;
      case (held_op)
         lxr_pkg::OP_PLUS:    k = lxr_pkg::KIND_PLUS;
         lxr_pkg::OP_MINUS:   k = lxr_pkg::KIND_MINUS;
         lxr_pkg::OP_STAR:    k = lxr_pkg::KIND_ASTERISK;
         lxr_pkg::OP_SLASH:   k = lxr_pkg::KIND_SLASH;
         lxr_pkg::OP_PERCENT: k = lxr_pkg::KIND_MODULO;
         lxr_pkg::OP_EQUAL:   k = lxr_pkg::KIND_ASSIGN;
         lxr_pkg::OP_LESS:    k = lxr_pkg::KIND_LESSTHAN;
         lxr_pkg::OP_GREATER: k = lxr_pkg::KIND_GREATERTHAN;
         default:             k = lxr_pkg::KIND_END;
      endcase
      if (held_op != lxr_pkg::OP_NONE) add_beat(beats, make_token(k, word_start, 16'd1));
      held_op = lxr_pkg::OP_NONE;
   endtask

   task automatic close_word(ref lxr_pkg::result_type beats [$]);
      if (word_kind == lxr_pkg::WORD_NUMBER || word_kind == lxr_pkg::WORD_IDENT) begin
         add_beat(beats, make_token(word_kind == lxr_pkg::WORD_NUMBER ?
                                    lxr_pkg::KIND_NUMBER : lxr_pkg::KIND_IDENTIFIER,
                                    word_start, word_length));
      end
      word_kind = lxr_pkg::WORD_NONE;
      word_length = '0;
   endtask

   task automatic lex_byte(input logic [7:0] c, input logic eot);
      lxr_pkg::result_type           beats [$];
      lxr_pkg::result_type           t;
      logic [lxr_pkg::KIND_BITS-1:0] k;
      logic [lxr_pkg::OP_BITS-1:0]   op;
      bit                            taken;
      taken = 1'b0;
      if (held_op != lxr_pkg::OP_NONE) begin
         k = lxr_pkg::KIND_END;
         case (held_op)
            lxr_pkg::OP_PLUS: begin
               if (c == lxr_pkg::CHAR_PLUS) k = lxr_pkg::KIND_INCREMENT;
               else if (c == lxr_pkg::CHAR_EQUAL) k = lxr_pkg::KIND_ADD_ASSIGN;
            end
            lxr_pkg::OP_MINUS: begin
               if (c == lxr_pkg::CHAR_MINUS) k = lxr_pkg::KIND_DECREMENT;
               else if (c == lxr_pkg::CHAR_EQUAL) k = lxr_pkg::KIND_SUB_ASSIGN;
            end
            lxr_pkg::OP_SLASH: begin
               if (c == lxr_pkg::CHAR_EQUAL) k = lxr_pkg::KIND_DIV_ASSIGN;
               else if (c == lxr_pkg::CHAR_SLASH) k = lxr_pkg::KIND_DOUBLESLASH;
            end
            lxr_pkg::OP_STAR:    if (c == lxr_pkg::CHAR_EQUAL) k = lxr_pkg::KIND_MUL_ASSIGN;
            lxr_pkg::OP_PERCENT: if (c == lxr_pkg::CHAR_EQUAL) k = lxr_pkg::KIND_MOD_ASSIGN;
            lxr_pkg::OP_EQUAL:   if (c == lxr_pkg::CHAR_EQUAL) k = lxr_pkg::KIND_EQUAL;
            lxr_pkg::OP_LESS:    if (c == lxr_pkg::CHAR_EQUAL) k = lxr_pkg::KIND_LESSEQUAL;
            lxr_pkg::OP_GREATER: if (c == lxr_pkg::CHAR_EQUAL) k = lxr_pkg::KIND_GREATEREQUAL;
            default:             k = lxr_pkg::KIND_END;
         endcase
         if (k != lxr_pkg::KIND_END) begin
            add_beat(beats, make_token(k, word_start, 16'd2));
            held_op = lxr_pkg::OP_NONE;
            taken = 1'b1;
         end else begin
            close_op(beats);
         end
      end
      if (!taken && word_kind != lxr_pkg::WORD_NONE) begin
         if ((word_kind == lxr_pkg::WORD_NUMBER) ? digit_char(c) : word_char(c)) begin
            if (word_length != lxr_pkg::LEN_MAX) word_length++;
            taken = 1'b1;
         end else begin
            close_word(beats);
         end
      end
      if (!taken && !(c == " " || (c >= 8'h09 && c <= 8'h0D))) begin
         case (c)
            lxr_pkg::CHAR_PLUS:    op = lxr_pkg::OP_PLUS;
            lxr_pkg::CHAR_MINUS:   op = lxr_pkg::OP_MINUS;
            lxr_pkg::CHAR_STAR:    op = lxr_pkg::OP_STAR;
            lxr_pkg::CHAR_SLASH:   op = lxr_pkg::OP_SLASH;
            lxr_pkg::CHAR_PERCENT: op = lxr_pkg::OP_PERCENT;
            lxr_pkg::CHAR_EQUAL:   op = lxr_pkg::OP_EQUAL;
            lxr_pkg::CHAR_LESS:    op = lxr_pkg::OP_LESS;
            lxr_pkg::CHAR_GREATER: op = lxr_pkg::OP_GREATER;
            default:               op = lxr_pkg::OP_NONE;
         endcase
         case (c)
            "?":     k = lxr_pkg::KIND_TERNARY;
            "(":     k = lxr_pkg::KIND_LPAREN;
            ")":     k = lxr_pkg::KIND_RPAREN;
            "[":     k = lxr_pkg::KIND_LBRACKET;
            "]":     k = lxr_pkg::KIND_RBRACKET;
            "{":     k = lxr_pkg::KIND_LBRACE;
            "}":     k = lxr_pkg::KIND_RBRACE;
            ",":     k = lxr_pkg::KIND_COMMA;
            ":":     k = lxr_pkg::KIND_COLON;
            default: k = lxr_pkg::KIND_END;
         endcase
         if (word_char(c)) begin
            word_kind = digit_char(c) ? lxr_pkg::WORD_NUMBER : lxr_pkg::WORD_IDENT;
            word_start = next_pos;
            word_length = 16'd1;
         end else if (op != lxr_pkg::OP_NONE) begin
            held_op = op;
            word_start = next_pos;
         end else if (k != lxr_pkg::KIND_END) begin
            add_beat(beats, make_token(k, next_pos, 16'd1));
         end else begin
            t = make_token(lxr_pkg::KIND_END, next_pos, 16'd1);
            t.is_error = 1'b1;
            t.bad_char = c;
            add_beat(beats, t);
         end
      end
      if (eot) begin
         close_op(beats);
         close_word(beats);
         next_pos = '0;
      end else begin
         next_pos++;
      end
      if (beats.size() > 0) beats[beats.size()-1].last_of_run = 1'b1;
      foreach (beats[i]) add_beat(lexed_tokens, beats[i]);
   endtask

   task automatic report_error(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) report_error($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic send_byte(input logic [7:0] c, input logic eot);
      int gap;
      int roll;
      gap = 0;
      if (!sender_steady) begin
         roll = $urandom_range(0, 99);
         if (roll >= 92) gap = $urandom_range(8, 30);
         else if (roll >= 60) gap = $urandom_range(1, 3);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.text_byte <= c;
      req_if.end_of_text <= eot;
      do @(posedge clock); while (!req_if.ready);
      lex_byte(c, eot);
   endtask

   task automatic send_text(input string s, input bit eot_last);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], eot_last && (i == s.len() - 1));
   endtask

   task automatic test_operator_tokens();
      // single operators flushed by single-character symbols, then every two-character operator
      send_text("=(+)-[*]/{%}<,>:?", 1'b0);
      send_text("++--+=-=*=/=//%===<=>=9", 1'b1);
   endtask

   task automatic test_words_and_errors();
      send_byte(8'h00, 1'b0);
      send_text("_a9\t12ab;", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h0B, 1'b0);
      send_byte(8'h80, 1'b0);
      send_text("x 7-", 1'b1);
   endtask

   task automatic test_long_word();
      string word_set;
      word_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      sender_steady = 1'b1;
      receiver_steady = 1'b1;
      send_byte("q", 1'b0);
      repeat (LONG_WORD) send_byte(word_set[$urandom_range(0, 62)], 1'b0);
      send_text(" 7+(", 1'b1);
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
   endtask

   task automatic test_backpressure();
      sender_steady = 1'b1;
      hold_cycles = 200;
      repeat (29) send_text("=(", 1'b0);
      send_text("=(", 1'b1);
      sender_steady = 1'b0;
   endtask

   task automatic test_random_texts();
      logic [7:0] text [$];
      string      word_set;
      string      op_chars;
      string      seconds;
      string      symbols;
      int         sent;
      int         roll;
      word_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      op_chars = "+-*/%=<>";
      seconds = "+-=/";
      symbols = "?()[]{},:";
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         text.delete();
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) add_char(text, 8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 14)) begin
               roll = $urandom_range(0, 99);
               if (roll < 22) begin
                  add_char(text, word_set[$urandom_range(0, 52)]);
                  repeat ($urandom_range(0, 6)) add_char(text, word_set[$urandom_range(0, 62)]);
               end else if (roll < 36) begin
                  repeat ($urandom_range(1, 5)) add_char(text, word_set[$urandom_range(53, 62)]);
               end else if (roll < 60) begin
                  add_char(text, op_chars[$urandom_range(0, 7)]);
                  if ($urandom_range(0, 1) == 1) add_char(text, seconds[$urandom_range(0, 3)]);
               end else if (roll < 74) begin
                  add_char(text, symbols[$urandom_range(0, 8)]);
               end else if (roll < 92) begin
                  if ($urandom_range(0, 1) == 1) add_char(text, " ");
                  else add_char(text, 8'(8'h09 + $urandom_range(0, 4)));
               end else begin
                  add_char(text, 8'($urandom_range(0, 255)));
               end
            end
         end
         foreach (text[i]) send_byte(text[i], i == text.size() - 1);
         sent += text.size();
      end
   endtask

   // result beat checker
   always @(posedge clock) begin
      lxr_pkg::result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (lexed_tokens.size() == 0) begin
            report_error($sformatf("token beat with none pending: kind %0d start %0d",
                                   rsp_if.token_kind, rsp_if.token_start));
         end else begin
            want = lexed_tokens.pop_front();
            compare_field("is_error", 16'(rsp_if.is_error), 16'(want.is_error));
            compare_field("token_kind", 16'(rsp_if.token_kind), 16'(want.token_kind));
            compare_field("token_start", rsp_if.token_start, want.token_start);
            compare_field("token_length", rsp_if.token_length, want.token_length);
            compare_field("bad_char", 16'(rsp_if.bad_char), 16'(want.bad_char));
            compare_field("last_of_run", 16'(rsp_if.last_of_run), 16'(want.last_of_run));
         end
      end
   end

   // result receiver with random stalls and long hold-offs on request
   initial begin
      int stall_left;
      int roll;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            stall_left = hold_cycles;
            hold_cycles = 0;
         end else if (stall_left == 0 && !receiver_steady) begin
            roll = $urandom_range(0, 99);
            if (roll < 20) stall_left = $urandom_range(1, 3);
            else if (roll < 23) stall_left = $urandom_range(10, 40);
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         report_error($sformatf("timeout with %0d tokens pending", lexed_tokens.size()));
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.text_byte = 8'h00;
      req_if.end_of_text = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_operator_tokens();
      test_words_and_errors();
      test_long_word();
      test_backpressure();
      test_random_texts();

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (lexed_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- c_style_lexer.f -----
design/lxr_pkg.sv
design/lxr_ifs.sv
design/lxr_front.sv
design/lxr_queue.sv
design/lxr_back.sv
design/c_style_lexer.sv
verif/c_style_lexer_tb.sv
